@@ sv/pcsm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcsm_pkg
// Shared types and constants for the python comment and string masker.
// ----------------------------------------------------------------------------
package pcsm_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   typedef enum logic [2:0] {
      MODE_CODE    = 3'd0,
      MODE_SQ      = 3'd1,
      MODE_DQ      = 3'd2,
      MODE_TSQ     = 3'd3,
      MODE_TDQ     = 3'd4,
      MODE_COMMENT = 3'd5
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] masked_byte;
      logic       final_out;
   } rsp_type;

   // one to three bytes ready for judging, oldest in slot 0
   typedef struct packed {
      logic [2:0][7:0] byte_list;
      logic [1:0]      byte_cnt;
      logic            tri_sq;
      logic            tri_dq;
      logic            last;
   } group_type;

endpackage

@@ sv/pcsm_front.sv @@
// ----------------------------------------------------------------------------
// pcsm_front
// Two-byte lookahead window; forms groups of bytes with triple-quote flags.
// ----------------------------------------------------------------------------
module pcsm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pcsm_pkg::req_type   req_payload,
   input  logic                queue_full,
   output logic                push,
   output pcsm_pkg::group_type push_data
);

   logic [7:0] b0_ff, b0_in;
   logic [7:0] b1_ff, b1_in;
   logic [1:0] held_ff, held_in;
   logic       accept;
   logic [7:0] x;
   logic       same3;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign x         = req_payload.source_byte;
   assign same3     = (held_ff == 2'd2) && (b0_ff == b1_ff) && (b1_ff == x);
   assign push      = accept && (req_payload.end_of_text || held_ff == 2'd2);

   always_comb begin
      push_data.byte_list = {x, b1_ff, b0_ff};
      push_data.byte_cnt  = 2'd1;
      push_data.tri_sq    = same3 && (b0_ff == pcsm_pkg::CH_SQUOTE);
      push_data.tri_dq    = same3 && (b0_ff == pcsm_pkg::CH_DQUOTE);
      push_data.last      = req_payload.end_of_text;
      if (req_payload.end_of_text) begin
         push_data.byte_cnt = held_ff + 2'd1;
         if (held_ff == 2'd1) begin
            push_data.byte_list = {x, x, b0_ff};
         end else if (held_ff == 2'd0) begin
            push_data.byte_list = {x, x, x};
         end
      end
   end

   always_comb begin
      b0_in   = b0_ff;
      b1_in   = b1_ff;
      held_in = held_ff;
      if (accept) begin
         if (req_payload.end_of_text) begin
            held_in = 2'd0;
         end else if (held_ff == 2'd2) begin
            b0_in = b1_ff;
            b1_in = x;
         end else if (held_ff == 2'd1) begin
            b1_in   = x;
            held_in = 2'd2;
         end else begin
            b0_in   = x;
            held_in = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      if (reset) begin
         held_ff <= 2'd0;
      end else begin
         held_ff <= held_in;
      end
   end

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff != 2'd3) else $error("lookahead count out of range");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.end_of_text |=> held_ff == 2'd0)
      else $error("window not flushed after end of text");

   a_push_full_window: assert property (@(posedge clock) disable iff (reset)
      push && !push_data.last |-> push_data.byte_cnt == 2'd1 && held_ff == 2'd2)
      else $error("group pushed before window filled");

endmodule

@@ sv/pcsm_queue.sv @@
// ----------------------------------------------------------------------------
// pcsm_queue
// Small queue of byte groups between the window and the lexer.
// ----------------------------------------------------------------------------
module pcsm_queue #(
   parameter int unsigned QUEUE_DEPTH = pcsm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcsm_pkg::group_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output pcsm_pkg::group_type head_data
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   pcsm_pkg::group_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

@@ sv/pcsm_back.sv @@
// ----------------------------------------------------------------------------
// pcsm_back
// Lexer state machine; judges one byte per cycle into a free output register.
// ----------------------------------------------------------------------------
module pcsm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  pcsm_pkg::group_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pcsm_pkg::rsp_type   rsp_payload
);

   pcsm_pkg::lex_mode_type mode_ff, mode_in;
   logic                   esc_ff, esc_in;
   logic [1:0]             skip_ff, skip_in;
   logic [1:0]             index_ff, index_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pcsm_pkg::rsp_type      rsp_ff, rsp_in;

   logic       step;
   logic       group_done;
   logic [7:0] ch;
   logic       tri_sq;
   logic       tri_dq;
   logic [7:0] hidden;
   logic [7:0] out_byte;
   logic [7:0] delim;

   assign step       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign group_done = (index_ff == head_data.byte_cnt - 2'd1);
   assign pop        = step && group_done;
   assign ch         = head_data.byte_list[index_ff];
   assign tri_sq     = head_data.tri_sq && (index_ff == 2'd0);
   assign tri_dq     = head_data.tri_dq && (index_ff == 2'd0);
   assign hidden     = (ch == pcsm_pkg::CH_NEWLINE) ? ch : pcsm_pkg::CH_SPACE;
   assign delim      = (mode_ff == pcsm_pkg::MODE_SQ) ? pcsm_pkg::CH_SQUOTE
                                                      : pcsm_pkg::CH_DQUOTE;

   // next state
   always_comb begin
      mode_in = mode_ff;
      esc_in  = esc_ff;
      skip_in = skip_ff;
      if (skip_ff != 2'd0) begin
         skip_in = skip_ff - 2'd1;
      end else begin
         unique case (mode_ff)
            pcsm_pkg::MODE_COMMENT: begin
               if (ch == pcsm_pkg::CH_NEWLINE) begin
                  mode_in = pcsm_pkg::MODE_CODE;
               end
            end
            pcsm_pkg::MODE_SQ, pcsm_pkg::MODE_DQ: begin
               if (!esc_ff && ch == delim) begin
                  mode_in = pcsm_pkg::MODE_CODE;
               end
               esc_in = !esc_ff && (ch == pcsm_pkg::CH_BACKSLASH);
            end
            pcsm_pkg::MODE_TSQ: begin
               if (tri_sq) begin
                  skip_in = 2'd2;
                  mode_in = pcsm_pkg::MODE_CODE;
               end
            end
            pcsm_pkg::MODE_TDQ: begin
               if (tri_dq) begin
                  skip_in = 2'd2;
                  mode_in = pcsm_pkg::MODE_CODE;
               end
            end
            default: begin
               priority if (ch == pcsm_pkg::CH_HASH) begin
                  mode_in = pcsm_pkg::MODE_COMMENT;
               end else if (tri_sq) begin
                  skip_in = 2'd2;
                  mode_in = pcsm_pkg::MODE_TSQ;
               end else if (tri_dq) begin
                  skip_in = 2'd2;
                  mode_in = pcsm_pkg::MODE_TDQ;
               end else if (ch == pcsm_pkg::CH_SQUOTE) begin
                  mode_in = pcsm_pkg::MODE_SQ;
                  esc_in  = 1'b0;
               end else if (ch == pcsm_pkg::CH_DQUOTE) begin
                  mode_in = pcsm_pkg::MODE_DQ;
                  esc_in  = 1'b0;
               end else begin
                  mode_in = mode_ff;
               end
            end
         endcase
      end
      // end of text returns the lexer to reset
      if (head_data.last && group_done) begin
         mode_in = pcsm_pkg::MODE_CODE;
         esc_in  = 1'b0;
         skip_in = 2'd0;
      end
   end

   // outputs
   always_comb begin
      out_byte = ch;
      if (skip_ff != 2'd0) begin
         out_byte = pcsm_pkg::CH_SPACE;
      end else begin
         unique case (mode_ff)
            pcsm_pkg::MODE_COMMENT: begin
               out_byte = hidden;
            end
            pcsm_pkg::MODE_SQ, pcsm_pkg::MODE_DQ,
            pcsm_pkg::MODE_TSQ, pcsm_pkg::MODE_TDQ: begin
               out_byte = hidden;
            end
            default: begin
               if (ch == pcsm_pkg::CH_HASH || tri_sq || tri_dq ||
                   ch == pcsm_pkg::CH_SQUOTE || ch == pcsm_pkg::CH_DQUOTE) begin
                  out_byte = pcsm_pkg::CH_SPACE;
               end else begin
                  out_byte = ch;
               end
            end
         endcase
      end
   end

   always_comb begin
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         index_in              = group_done ? 2'd0 : index_ff + 2'd1;
         rsp_valid_in          = 1'b1;
         rsp_in.masked_byte    = out_byte;
         rsp_in.final_out      = head_data.last && group_done;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         mode_ff      <= pcsm_pkg::MODE_CODE;
         esc_ff       <= 1'b0;
         skip_ff      <= 2'd0;
         index_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            mode_ff <= mode_in;
            esc_ff  <= esc_in;
            skip_ff <= skip_in;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_index_in_group: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> index_ff < head_data.byte_cnt)
      else $error("group index past byte count");

   a_escape_in_string: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> mode_ff == pcsm_pkg::MODE_SQ || mode_ff == pcsm_pkg::MODE_DQ)
      else $error("escape pending outside one-line string");

   a_skip_mode: assert property (@(posedge clock) disable iff (reset)
      skip_ff != 2'd0 |-> mode_ff == pcsm_pkg::MODE_CODE ||
         mode_ff == pcsm_pkg::MODE_TSQ || mode_ff == pcsm_pkg::MODE_TDQ)
      else $error("skip count outside triple quote");

   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      step && head_data.last && group_done |=>
         mode_ff == pcsm_pkg::MODE_CODE && skip_ff == 2'd0 && !esc_ff)
      else $error("lexer not reset after end of text");

endmodule

@@ sv/python_comment_string_masker_unit.sv @@
// ----------------------------------------------------------------------------
// python_comment_string_masker_unit
// Masks comments and string literals of python source to spaces, keeping newlines.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          word
//   req_     in         req_valid/ready    source_byte, end_of_text
//   rsp_     out        rsp_valid/ready    masked_byte, final_out
//
// one byte per cycle through the lexer unless the output stalls; a word
// enters every cycle while the queue has room. a word's result leaves two
// words later, after the window. end of text flushes up to three bytes.
// synchronous active-high reset; no clearing pass after reset.
// either side may stall; the queue and output register decouple them.
// ----------------------------------------------------------------------------
module python_comment_string_masker_unit #(
   parameter int unsigned QUEUE_DEPTH = pcsm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcsm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcsm_pkg::rsp_type rsp_payload
);

   logic                queue_full;
   logic                push;
   pcsm_pkg::group_type push_data;
   logic                pop;
   logic                head_valid;
   pcsm_pkg::group_type head_data;

   pcsm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   pcsm_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   pcsm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/pcsm_mask_checker.sv @@
// ----------------------------------------------------------------------------
// pcsm_mask_checker
// Watches both channels of the masker, tracks the python lexer state for
// every accepted source word, and compares each masked word leaving the
// block with the oldest predicted one.
// ----------------------------------------------------------------------------
module pcsm_mask_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pcsm_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pcsm_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   pcsm_pkg::lex_mode_type scan_mode;
   logic                   in_escape;
   logic [1:0][7:0]        held_bytes;
   int                     held_n;
   int                     skip_n;
   pcsm_pkg::rsp_type      masked_q [$];

   function automatic bit quote_run(logic [2:0][7:0] win, int k, int n, logic [7:0] q);
      return (k + 2 < n) && win[k] == q && win[k + 1] == q && win[k + 2] == q;
   endfunction

   function automatic logic [7:0] mask_one_byte(logic [2:0][7:0] win, int k, int n);
      logic [7:0] ch;
      logic [7:0] hidden;
      logic [7:0] q;
      ch = win[k];
      hidden = (ch == pcsm_pkg::CH_NEWLINE) ? ch : pcsm_pkg::CH_SPACE;
      if (skip_n != 0) begin
         skip_n--;
         return pcsm_pkg::CH_SPACE;
      end
      case (scan_mode)
         pcsm_pkg::MODE_COMMENT: begin
            if (ch == pcsm_pkg::CH_NEWLINE) begin
               scan_mode = pcsm_pkg::MODE_CODE;
               return ch;
            end
            return pcsm_pkg::CH_SPACE;
         end
         pcsm_pkg::MODE_SQ, pcsm_pkg::MODE_DQ: begin
            q = (scan_mode == pcsm_pkg::MODE_SQ) ? pcsm_pkg::CH_SQUOTE : pcsm_pkg::CH_DQUOTE;
            if (!in_escape && ch == q)
               scan_mode = pcsm_pkg::MODE_CODE;
            in_escape = !in_escape && ch == pcsm_pkg::CH_BACKSLASH;
            return hidden;
         end
         pcsm_pkg::MODE_TSQ, pcsm_pkg::MODE_TDQ: begin
            q = (scan_mode == pcsm_pkg::MODE_TSQ) ? pcsm_pkg::CH_SQUOTE : pcsm_pkg::CH_DQUOTE;
            if (quote_run(win, k, n, q)) begin
               skip_n = 2;
               scan_mode = pcsm_pkg::MODE_CODE;
            end
            return hidden;
         end
         default: begin
            if (ch == pcsm_pkg::CH_HASH) begin
               scan_mode = pcsm_pkg::MODE_COMMENT;
               return pcsm_pkg::CH_SPACE;
            end
            if (quote_run(win, k, n, pcsm_pkg::CH_SQUOTE)) begin
               skip_n = 2;
               scan_mode = pcsm_pkg::MODE_TSQ;
               return pcsm_pkg::CH_SPACE;
            end
            if (quote_run(win, k, n, pcsm_pkg::CH_DQUOTE)) begin
               skip_n = 2;
               scan_mode = pcsm_pkg::MODE_TDQ;
               return pcsm_pkg::CH_SPACE;
            end
            if (ch == pcsm_pkg::CH_SQUOTE) begin
               scan_mode = pcsm_pkg::MODE_SQ;
               in_escape = 1'b0;
               return pcsm_pkg::CH_SPACE;
            end
            if (ch == pcsm_pkg::CH_DQUOTE) begin
               scan_mode = pcsm_pkg::MODE_DQ;
               in_escape = 1'b0;
               return pcsm_pkg::CH_SPACE;
            end
            return ch;
         end
      endcase
   endfunction

   function automatic void clear_scan();
      scan_mode = pcsm_pkg::MODE_CODE;
      in_escape = 1'b0;
      held_bytes = '0;
      held_n = 0;
      skip_n = 0;
   endfunction

   function automatic void predict_masked_words(pcsm_pkg::req_type w);
      logic [2:0][7:0]   win;
      int                n;
      pcsm_pkg::rsp_type r;
      win = '0;
      n = held_n;
      for (int k = 0; k < n; k++)
         win[k] = held_bytes[k];
      win[n] = w.source_byte;
      n++;
      if (w.end_of_text) begin
         for (int k = 0; k < n; k++) begin
            r.masked_byte = mask_one_byte(win, k, n);
            r.final_out = (k + 1 == n);
            masked_q.insert(masked_q.size(), r);
         end
         clear_scan();
      end else if (n < 3) begin
         for (int k = 0; k < n; k++)
            held_bytes[k] = win[k];
         held_n = n;
      end else begin
         r.masked_byte = mask_one_byte(win, 0, 3);
         r.final_out = 1'b0;
         masked_q.insert(masked_q.size(), r);
         held_bytes[0] = win[1];
         held_bytes[1] = win[2];
         held_n = 2;
      end
   endfunction

   always @(posedge clock) begin
      pcsm_pkg::rsp_type want;
      if (reset) begin
         clear_scan();
         masked_q.delete();
         fail_count = 0;
         checked_count = 0;
      end else begin
         if (req_valid && req_ready)
            predict_masked_words(req_payload);
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (masked_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected word: masked_byte=%02h final_out=%0b",
                           $realtime, rsp_payload.masked_byte, rsp_payload.final_out);
               fail_count++;
            end else begin
               want = masked_q.pop_front();
               if (rsp_payload.masked_byte !== want.masked_byte ||
                   rsp_payload.final_out !== want.final_out) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch: masked_byte exp %02h got %02h, ",
                               "final_out exp %0b got %0b"},
                              $realtime, want.masked_byte, rsp_payload.masked_byte,
                              want.final_out, rsp_payload.final_out);
                  fail_count++;
               end
            end
         end
      end
      pending_count = masked_q.size();
   end

endmodule

@@ tb/tb_python_comment_string_masker_unit.sv @@
// ----------------------------------------------------------------------------
// tb_python_comment_string_masker_unit
// Feeds short python-like texts through the masker, with directed texts for
// comments, escapes, triple quotes and text ends, then random texts, while
// both channels stall at random. The checker module does the comparing.
// ----------------------------------------------------------------------------
module tb_python_comment_string_masker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_TARGET = 270;
   localparam int IDLE_LIMIT = 1000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pcsm_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pcsm_pkg::rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int checked_count;

   int         words_sent = 0;
   int         texts_sent = 0;
   int         burst_left = 8;
   int         idle_cycles = 0;
   logic [7:0] ready_cycle = '0;
   logic [7:0] text_buf [$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   python_comment_string_masker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   pcsm_mask_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // receiver: always ready, light stalls, heavy stalls, then regular on/off blocks
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_cycle <= '0;
      end else begin
         ready_cycle <= ready_cycle + 8'd1;
         case (ready_cycle[7:6])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= ready_cycle[2];
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d words outstanding",
                  idle_cycles, pending_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      pcsm_pkg::req_type w;
      int                gap;
      w.source_byte = b;
      w.end_of_text = last;
      req_payload <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_word(text_buf[i], i == text_buf.size() - 1);
      texts_sent++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   task automatic load_string(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   task automatic build_random_text();
      int         len;
      int         pick;
      logic [7:0] q;
      text_buf.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      while (text_buf.size() < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            add_byte(8'($urandom_range(8'h61, 8'h7a)));
         else if (pick < 38)
            add_byte(pcsm_pkg::CH_SPACE);
         else if (pick < 46)
            add_byte(pcsm_pkg::CH_NEWLINE);
         else if (pick < 54)
            add_byte(pcsm_pkg::CH_HASH);
         else if (pick < 64)
            add_byte(pcsm_pkg::CH_SQUOTE);
         else if (pick < 74)
            add_byte(pcsm_pkg::CH_DQUOTE);
         else if (pick < 80)
            add_byte(pcsm_pkg::CH_BACKSLASH);
         else if (pick < 88) begin
            q = ($urandom_range(0, 1) != 0) ? pcsm_pkg::CH_SQUOTE : pcsm_pkg::CH_DQUOTE;
            repeat (3) add_byte(q);
         end else
            add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // one-word texts at the byte extremes
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b1);
      texts_sent += 2;
      // comment, then a quoted string with an escaped quote
      load_string("#a\n'\\''");
      send_text();
      // newline inside a double-quoted string
      load_string("\"x\n\"");
      send_text();
      // triple single-quoted string, opened and closed
      load_string("'''a'''");
      send_text();
      // triple double quote as the whole text, left open
      load_string("\"\"\"");
      send_text();
      // two quotes at the very end
      load_string("x''");
      send_text();

      while (words_sent < WORD_TARGET) begin
         build_random_text();
         send_text();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("%0d source words in %0d texts, %0d masked words checked",
               words_sent, texts_sent, checked_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/pcsm_pkg.sv
sv/pcsm_front.sv
sv/pcsm_queue.sv
sv/pcsm_back.sv
sv/python_comment_string_masker_unit.sv
tb/pcsm_mask_checker.sv
tb/tb_python_comment_string_masker_unit.sv
